>>> sv/oqfmm_pkg.sv
// ============================================================================
// Ordered queue package
// Types and codes shared by the cell row, the result buffer and the top level.
// ============================================================================
`default_nettype none

package oqfmm_pkg;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_MIN  = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;

    localparam logic       FUNC_ENQ  = 1'b0;
    localparam logic       FUNC_DEQ  = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               enq;
        logic               deq;
        logic               mode_min;
        logic               mode_max;
        logic signed [31:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [4:0]         occupancy;
    } t_result;

endpackage

`default_nettype wire

>>> sv/oqfmm_cell.sv
// ============================================================================
// Ordered queue cell
// Holds one entry, decides whether a new value belongs here and shifts toward
// its neighbors on insert or removal.
// ============================================================================
`default_nettype none

module oqfmm_cell (
    input  wire                    i_clk,
    input  oqfmm_pkg::t_cell_cmd   i_cmd,
    input  wire                    i_occupied,
    input  wire                    i_found,
    input  wire signed [31:0]      i_left_value,
    input  wire signed [31:0]      i_right_value,
    output logic                   o_found,
    output logic signed [31:0]     o_value
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_here;

    always_comb begin
        w_here = !i_occupied
               || (i_cmd.mode_min && !(r_value < i_cmd.value))
               || (i_cmd.mode_max && !(i_cmd.value < r_value));
        o_found = i_found || w_here;
    end

    always_comb begin
        n_value = r_value;
        if (i_cmd.enq) begin
            if (i_found) begin
                n_value = i_left_value;
            end else if (w_here) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.deq) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

>>> sv/oqfmm_rbuf.sv
// ============================================================================
// Ordered queue result buffer
// Two-slot queue of results that decouples the output stall from the input.
// ============================================================================
`default_nettype none

module oqfmm_rbuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  oqfmm_pkg::t_result  i_result,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_stall,
    output oqfmm_pkg::t_result  o_result
);

    oqfmm_pkg::t_result r_slot [2];
    logic               r_wr;
    logic               n_wr;
    logic               r_rd;
    logic               n_rd;
    logic [1:0]         r_fill;
    logic [1:0]         n_fill;
    logic               w_pop;

    assign w_pop   = o_valid && !i_stall;
    assign o_valid = (r_fill != 2'd0);
    assign o_full  = (r_fill == 2'd2);
    assign o_result = r_slot[r_rd];

    always_comb begin
        n_wr   = i_push ? !r_wr : r_wr;
        n_rd   = w_pop ? !r_rd : r_rd;
        n_fill = r_fill + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> sv/ordered_queue_fifo_min_max.sv
// ============================================================================
// Ordered queue with FIFO, min-first and max-first order
// Bounded queue of signed values kept in a row of compare-and-shift cells.
// ============================================================================
//
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall i_func, i_value_in
// result    out        o_out_valid/i_out_stall o_status, o_value_out, o_occupancy
// config    in         i_cfg_valid/o_cfg_ready i_cfg_data (order mode)
//
// One request can be accepted every cycle while the input is not stalled;
// every cell compares and shifts in the same cycle, so the row sets the rate.
// A result appears in the cycle after its request and waits in a two-slot buffer.
// The input stalls only while both result slots are occupied.
// Reset empties the queue and the buffer and selects FIFO order; the cell
// contents are not cleared.
`default_nettype none

module ordered_queue_fifo_min_max #(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_func,
    input  wire signed [31:0]  i_value_in,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [4:0]         o_occupancy,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]          r_mode;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_buf_full;
    oqfmm_pkg::t_cell_cmd w_cmd;
    oqfmm_pkg::t_result  w_result;
    oqfmm_pkg::t_result  w_out;
    logic                w_found [DEPTH+1];
    logic signed [31:0]  w_value [DEPTH];
    logic [CW+4:0]       w_occ_wide;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_buf_full;
    assign w_accept    = i_in_valid && !w_buf_full;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_cmd.enq      = w_accept && (i_func == oqfmm_pkg::FUNC_ENQ) && !w_full;
        w_cmd.deq      = w_accept && (i_func == oqfmm_pkg::FUNC_DEQ) && !w_empty;
        w_cmd.mode_min = (r_mode == oqfmm_pkg::MODE_MIN);
        w_cmd.mode_max = (r_mode == oqfmm_pkg::MODE_MAX);
        w_cmd.value    = i_value_in;
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        w_occ_wide = {5'd0, n_count};
        w_result.occupancy = w_occ_wide[4:0];
        w_result.value_out = w_cmd.deq ? w_value[0] : 32'sd0;
        w_result.status    = oqfmm_pkg::STATUS_DONE;
        if (i_func == oqfmm_pkg::FUNC_ENQ && w_full) begin
            w_result.status = oqfmm_pkg::STATUS_FULL;
        end else if (i_func == oqfmm_pkg::FUNC_DEQ && w_empty) begin
            w_result.status = oqfmm_pkg::STATUS_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= oqfmm_pkg::MODE_FIFO;
            r_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = 32'sd0;
        end else begin : g_mid
            assign w_left = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = 32'sd0;
        end else begin : g_inner
            assign w_right = w_value[g+1];
        end
        oqfmm_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_occupied    (CW'(g) < r_count),
            .i_found       (w_found[g]),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .o_found       (w_found[g+1]),
            .o_value       (w_value[g])
        );
    end

    oqfmm_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_result (w_result),
        .o_full   (w_buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out)
    );

    assign o_status    = w_out.status;
    assign o_value_out = w_out.value_out;
    assign o_occupancy = w_out.occupancy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.enq |=> r_count == $past(r_count) + CW'(1))
        else $error("An accepted enqueue did not add an entry.");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deq |=> r_count == $past(r_count) - CW'(1))
        else $error("An accepted dequeue did not remove an entry.");

    a_result_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("An accepted request produced no result.");

endmodule

`default_nettype wire

>>> test/ordered_queue_fifo_min_max_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Ordered queue testbench
// Drives enqueue and dequeue requests in FIFO, min-first, max-first and the
// spare order mode. A short table of directed requests comes first, then
// random bursts under several idling patterns. Each result is compared with
// the typed table row or else a behavioral queue model in the testbench.
// ============================================================================

module ordered_queue_fifo_min_max_test;

    typedef oqfmm_pkg::t_result t_result;

    localparam logic [1:0] MODE_FIFO    = oqfmm_pkg::MODE_FIFO;
    localparam logic [1:0] MODE_MIN     = oqfmm_pkg::MODE_MIN;
    localparam logic [1:0] MODE_MAX     = oqfmm_pkg::MODE_MAX;
    localparam logic       FUNC_ENQ     = oqfmm_pkg::FUNC_ENQ;
    localparam logic       FUNC_DEQ     = oqfmm_pkg::FUNC_DEQ;
    localparam logic [1:0] STATUS_DONE  = oqfmm_pkg::STATUS_DONE;
    localparam logic [1:0] STATUS_EMPTY = oqfmm_pkg::STATUS_EMPTY;
    localparam logic [1:0] STATUS_FULL  = oqfmm_pkg::STATUS_FULL;

    localparam int         DEPTH           = 16;
    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam int         ITEMS_PER_PHASE = 160;
    localparam int         PHASES          = 8;
    localparam int         DIRECTED_ROWS   = 25;

    typedef struct packed {
        logic [1:0]         mode;
        logic               func;
        logic signed [31:0] value;
        logic [4:0]         reps;
        logic               typed;
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [4:0]         occupancy;
    } t_stim_row;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_FIFO,  FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{MODE_FIFO,  FUNC_ENQ, 32'h7FFF_FFFF, 5'd1,  1'b1, STATUS_DONE,  32'h0000_0000, 5'd1},
        '{MODE_FIFO,  FUNC_ENQ, 32'h8000_0000, 5'd1,  1'b1, STATUS_DONE,  32'h0000_0000, 5'd2},
        '{MODE_FIFO,  FUNC_ENQ, 32'h0000_0000, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_FIFO,  FUNC_ENQ, 32'hFFFF_FFFF, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_FIFO,  FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_DONE,  32'h7FFF_FFFF, 5'd3},
        '{MODE_FIFO,  FUNC_DEQ, 32'hFFFF_FFFF, 5'd3,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_FIFO,  FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_ENQ, 32'h0000_0005, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_ENQ, 32'hFFFF_FFFD, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_ENQ, 32'h0000_0005, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_ENQ, 32'h8000_0000, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_ENQ, 32'h7FFF_FFFF, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MIN,   FUNC_DEQ, 32'h0000_0000, 5'd2,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MAX,   FUNC_ENQ, 32'h0000_0006, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MAX,   FUNC_ENQ, 32'h8000_0000, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MAX,   FUNC_ENQ, 32'h7FFF_FFFF, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MAX,   FUNC_DEQ, 32'h0000_0000, 5'd6,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_MAX,   FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000, 5'd0},
        '{MODE_SPARE, FUNC_ENQ, 32'h5A5A_5A5A, 5'd16, 1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_SPARE, FUNC_ENQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_FULL,  32'h0000_0000, 5'd16},
        '{MODE_SPARE, FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_DONE,  32'h5A5A_5A5A, 5'd15},
        '{MODE_SPARE, FUNC_ENQ, 32'h8000_0000, 5'd1,  1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_SPARE, FUNC_DEQ, 32'h0000_0000, 5'd16, 1'b0, STATUS_DONE,  32'h0000_0000, 5'd0},
        '{MODE_SPARE, FUNC_DEQ, 32'h0000_0000, 5'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000, 5'd0}
    };

    localparam logic [1:0] PHASE_MODES [PHASES] = '{
        MODE_MIN, MODE_MAX, MODE_FIFO, MODE_SPARE, MODE_MAX, MODE_MIN, MODE_FIFO, MODE_MAX
    };

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_func      = FUNC_ENQ;
    logic signed [31:0] i_value_in  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_value_out;
    logic [4:0]         o_occupancy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_data  = MODE_FIFO;

    logic               req_typed        = 1'b0;
    t_result            req_typed_result = '0;

    logic signed [31:0] model_entries [DEPTH];
    int                 model_count = 0;
    logic [1:0]         model_mode  = MODE_FIFO;
    t_result            expected_results [$];
    t_result            predicted;
    int                 error_count    = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;

    ordered_queue_fifo_min_max #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_occupancy (o_occupancy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ordered_queue_fifo_min_max: mismatch");
        $finish;
    end

    function automatic t_result queue_step(input logic func, input logic signed [31:0] value);
        t_result r;
        int      pos;
        r = '0;
        if (func == FUNC_ENQ) begin
            if (model_count >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                pos = model_count;
                for (int i = model_count - 1; i >= 0; i--) begin
                    if (model_mode == MODE_MIN && model_entries[i] >= value) begin
                        pos = i;
                    end
                    if (model_mode == MODE_MAX && model_entries[i] <= value) begin
                        pos = i;
                    end
                end
                for (int i = model_count; i > pos; i--) begin
                    model_entries[i] = model_entries[i - 1];
                end
                model_entries[pos] = value;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.value_out = model_entries[0];
                for (int i = 1; i < model_count; i++) begin
                    model_entries[i - 1] = model_entries[i];
                end
                model_count--;
            end
        end
        r.occupancy = model_count[4:0];
        return r;
    endfunction

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result without a pending request: status %0d value_out %0d occupancy %0d",
                   o_status, o_value_out, o_occupancy);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (o_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, o_status);
                error_count++;
            end
            if (o_value_out !== want.value_out) begin
                $error("value_out: expected %0d, actual %0d", want.value_out, o_value_out);
                error_count++;
            end
            if (o_occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, o_occupancy);
                error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = queue_step(i_func, i_value_in);
                expected_results.push_back(req_typed ? req_typed_result : predicted);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                model_mode = i_cfg_data;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(input logic func, input logic signed [31:0] value,
                                input logic typed, input t_result typed_result);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= func;
        i_value_in       <= value;
        req_typed        <= typed;
        req_typed_result <= typed_result;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_order_mode(input logic [1:0] mode);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return int'($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_result    typed_result;
        logic [1:0] current_mode;
        int         sent;
        int         burst_len;
        int         enq_pct;

        current_mode = MODE_FIFO;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].mode != current_mode) begin
                write_order_mode(DIRECTED[r].mode);
                current_mode = DIRECTED[r].mode;
            end
            typed_result.status    = DIRECTED[r].status;
            typed_result.value_out = DIRECTED[r].value_out;
            typed_result.occupancy = DIRECTED[r].occupancy;
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                send_request(DIRECTED[r].func, DIRECTED[r].value, DIRECTED[r].typed,
                             typed_result);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            write_order_mode(PHASE_MODES[phase]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst_len = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    default: enq_pct = 50;
                endcase
                if ($urandom_range(9) == 0) begin
                    drain_results();
                end
                repeat (burst_len) begin
                    send_request(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                                 random_value(), 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ordered_queue_fifo_min_max: match");
        end else begin
            $display("ordered_queue_fifo_min_max: mismatch");
        end
        $finish;
    end

endmodule
